[rtl/assert_macros.svh]
// assertion macros used by the checker file
// needs signals named clock and reset in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define EFR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, disabled while reset is high
`define EFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

[rtl/efr_pkg.sv]
// types and constants of the escaped frame receiver
// no dependencies
`timescale 1ns / 1ps

package efr_pkg;

   localparam int BYTE_W        = 8;
   localparam int PAYLOAD_DEPTH = 256;
   localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
   localparam int CSR_INDEX_W   = 1;

   localparam logic [BYTE_W-1:0] MIN_FRAME_LENGTH = 8'd4;
   localparam logic [BYTE_W-1:0] MARK_RESET       = 8'd255;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET     = 8'd238;

   localparam logic [CSR_INDEX_W-1:0] CSR_MARK   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ESCAPE = 1'b1;

   typedef enum logic [2:0] {
      PH_HEAD   = 3'd0,
      PH_LENGTH = 3'd1,
      PH_PROP   = 3'd2,
      PH_DATA   = 3'd3,
      PH_TAIL   = 3'd4
   } phase_type;

endpackage

[rtl/efr_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module efr_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/escaped_frame_receiver_top.sv]
// top level of the escaped frame receiver: frame parser, payload memory, output stage
// depends on efr_pkg and efr_ram
`timescale 1ns / 1ps

// Takes one transaction per clock: either a received serial byte or a read of a stored
// payload byte. Bytes are parsed as mark, length, property, payload, mark; escape bytes
// before payload marks are dropped, and each frame closed by a mark gives one notice
// with its property and payload count. A read reply or notice passes the middle stage
// and leaves the block from an output register. The parser updates its small state
// once per accepted byte, and the payload memory is used by at most one transaction
// per cycle (a write for a payload byte, a read for a read transaction), so sustained
// rate is one transaction per cycle while no result is held. The request side stalls
// only while a result waits in the middle stage and the output register is held. The
// payload memory needs no clearing after reset; reading a never-written entry gives
// arbitrary data.
module escaped_frame_receiver_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [efr_pkg::BYTE_W-1:0]      req_rx_byte,
   input  logic [efr_pkg::BYTE_W-1:0]      req_read_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_is_read_reply,
   output logic [efr_pkg::BYTE_W-1:0]      rsp_frame_property,
   output logic [efr_pkg::BYTE_W-1:0]      rsp_payload_count,
   output logic [efr_pkg::BYTE_W-1:0]      rsp_read_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [efr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [efr_pkg::BYTE_W-1:0]      csr_wdata
);

   // configuration
   logic [efr_pkg::BYTE_W-1:0] mark_ff;
   logic [efr_pkg::BYTE_W-1:0] escape_ff;

   // parser state
   efr_pkg::phase_type         phase_ff, phase_in, eff_phase;
   logic [efr_pkg::BYTE_W-1:0] prev_ff;
   logic [efr_pkg::BYTE_W-1:0] rem_ff, rem_in, rem_dec;
   logic [efr_pkg::BYTE_W-1:0] cnt_ff, cnt_in, cnt_adj;
   logic [efr_pkg::BYTE_W-1:0] prop_ff, prop_in;

   logic is_mark, mark_seen, restart, unescape, short_len;
   logic notice, wr_req, wr_in_range;

   // handshake
   logic out_free, req_accept, byte_accept, read_accept;

   // middle stage
   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_is_read_ff;
   logic                       s1_in_range_ff;
   logic [efr_pkg::BYTE_W-1:0] s1_prop_ff;
   logic [efr_pkg::BYTE_W-1:0] s1_cnt_ff;

   // output stage
   logic                       rsp_valid_ff;
   logic                       rsp_is_read_ff;
   logic [efr_pkg::BYTE_W-1:0] rsp_prop_ff, rsp_cnt_ff, rsp_data_ff;

   logic [efr_pkg::BYTE_W-1:0] ram_rd_data;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !out_free;
   assign req_accept  = req_valid && !req_stall;
   assign byte_accept = req_accept && !req_action;
   assign read_accept = req_accept && req_action;
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff   <= efr_pkg::MARK_RESET;
         escape_ff <= efr_pkg::ESCAPE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            efr_pkg::CSR_MARK:   mark_ff   <= csr_wdata;
            efr_pkg::CSR_ESCAPE: escape_ff <= csr_wdata;
         endcase
      end
   end

   // next state of the parser
   always_comb begin
      is_mark   = req_rx_byte == mark_ff;
      mark_seen = is_mark && (phase_ff != efr_pkg::PH_TAIL);
      restart   = mark_seen && (prev_ff != escape_ff);
      unescape  = mark_seen && (prev_ff == escape_ff);
      eff_phase = restart ? efr_pkg::PH_HEAD : phase_ff;
      short_len = req_rx_byte < efr_pkg::MIN_FRAME_LENGTH;
      rem_dec   = rem_ff - 8'd1;
      phase_in  = phase_ff;
      unique case (eff_phase)
         efr_pkg::PH_HEAD:   phase_in = efr_pkg::PH_LENGTH;
         efr_pkg::PH_LENGTH: phase_in = short_len ? efr_pkg::PH_HEAD : efr_pkg::PH_PROP;
         efr_pkg::PH_PROP: begin
            phase_in = (rem_ff == efr_pkg::MIN_FRAME_LENGTH) ? efr_pkg::PH_TAIL
                                                              : efr_pkg::PH_DATA;
         end
         efr_pkg::PH_DATA: begin
            phase_in = (rem_dec == efr_pkg::MIN_FRAME_LENGTH) ? efr_pkg::PH_TAIL
                                                               : efr_pkg::PH_DATA;
         end
         efr_pkg::PH_TAIL:   phase_in = efr_pkg::PH_HEAD;
         default:            phase_in = phase_ff;
      endcase
   end

   // parser outputs and data updates
   always_comb begin
      cnt_adj     = (unescape && (cnt_ff != '0)) ? cnt_ff - 8'd1 : cnt_ff;
      wr_in_range = (9'(cnt_adj) < 9'(efr_pkg::PAYLOAD_DEPTH));
      cnt_in      = cnt_adj;
      rem_in      = rem_ff;
      prop_in     = prop_ff;
      wr_req      = 1'b0;
      notice      = 1'b0;
      unique case (eff_phase)
         efr_pkg::PH_HEAD: begin
         end
         efr_pkg::PH_LENGTH: begin
            if (!short_len) begin
               rem_in = req_rx_byte;
               cnt_in = '0;
            end
         end
         efr_pkg::PH_PROP: begin
            prop_in = req_rx_byte;
         end
         efr_pkg::PH_DATA: begin
            rem_in = rem_dec;
            wr_req = wr_in_range;
            cnt_in = cnt_adj + 8'd1;
         end
         efr_pkg::PH_TAIL: begin
            notice = is_mark;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= efr_pkg::PH_HEAD;
         prev_ff  <= '0;
         rem_ff   <= '0;
         cnt_ff   <= '0;
         prop_ff  <= '0;
      end else if (byte_accept) begin
         phase_ff <= phase_in;
         prev_ff  <= req_rx_byte;
         rem_ff   <= rem_in;
         cnt_ff   <= cnt_in;
         prop_ff  <= prop_in;
      end
   end

   efr_ram #(
      .WIDTH (efr_pkg::BYTE_W),
      .DEPTH (efr_pkg::PAYLOAD_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (byte_accept && wr_req),
      .wr_addr (cnt_adj[efr_pkg::ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (read_accept),
      .rd_addr (req_read_index[efr_pkg::ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // middle stage, aligned with the memory read
   assign s1_valid_in = read_accept || (byte_accept && notice);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_valid_ff || out_free) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_is_read_ff  <= req_action;
         s1_in_range_ff <= (9'(req_read_index) < 9'(efr_pkg::PAYLOAD_DEPTH));
         s1_prop_ff     <= prop_ff;
         s1_cnt_ff      <= cnt_adj;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         rsp_is_read_ff <= s1_is_read_ff;
         rsp_prop_ff    <= s1_is_read_ff ? '0 : s1_prop_ff;
         rsp_cnt_ff     <= s1_is_read_ff ? '0 : s1_cnt_ff;
         rsp_data_ff    <= (s1_is_read_ff && s1_in_range_ff) ? ram_rd_data : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_read_reply  = rsp_is_read_ff;
   assign rsp_frame_property = rsp_prop_ff;
   assign rsp_payload_count  = rsp_cnt_ff;
   assign rsp_read_data      = rsp_data_ff;

endmodule

[rtl/efr_checker.sv]
// port-level checks of the escaped frame receiver, bound to the top level
// depends on assert_macros.svh and escaped_frame_receiver_top
`timescale 1ns / 1ps
`include "assert_macros.svh"

module efr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_is_read_reply,
   input logic [7:0] rsp_frame_property,
   input logic [7:0] rsp_payload_count,
   input logic [7:0] rsp_read_data
);

   // held transaction keeps its payload
   `EFR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_is_read_reply) && $stable(rsp_frame_property) && $stable(rsp_payload_count) && $stable(rsp_read_data))

   // requests stall only behind a held result
   `EFR_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid && rsp_stall)

   // a fresh result comes from an accepted transaction that passed the middle stage
   `EFR_ASSERT_IMP(a_rsp_origin, $rose(rsp_valid), $past(req_valid && !req_stall, 2))

   // unused fields of each result kind are zero
   `EFR_ASSERT_IMP(a_rsp_fill, rsp_valid, rsp_is_read_reply ? (rsp_frame_property == 8'd0 && rsp_payload_count == 8'd0) : (rsp_read_data == 8'd0))

endmodule

bind escaped_frame_receiver_top efr_checker u_efr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_is_read_reply  (rsp_is_read_reply),
   .rsp_frame_property (rsp_frame_property),
   .rsp_payload_count  (rsp_payload_count),
   .rsp_read_data      (rsp_read_data)
);
